### src/lpsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsl_pkg
// Shared types and constants for the length-prefixed string list parser.
// ----------------------------------------------------------------------------
package lpsl_pkg;

   localparam int MAX_STRINGS_DEFAULT = 4096;
   localparam int LEN_SAT             = 4096;
   // result queue depth, must be a power of two and at least 2
   localparam int RSP_DEPTH           = 4;

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_LEN   = 3'd1,
      PH_PAY   = 3'd2,
      PH_TAIL  = 3'd3,
      PH_ERR   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_DONE  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_SHORT  = 3'd1,
      ST_BIG    = 3'd2,
      ST_CUTLEN = 3'd3,
      ST_CUTPAY = 3'd4,
      ST_TRAIL  = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_request;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [11:0] string_index;
      logic [12:0] string_length;
      logic [7:0]  payload_byte;
      status_type  status;
      logic        last_result;
   } rsp_type;

   // up to two results per item: byte-driven result first, end status second
   typedef struct packed {
      logic    first_valid;
      rsp_type first;
      logic    second_valid;
      rsp_type second;
   } push_type;

endpackage

### src/lpsl_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsl_parse
// Parser state and per-item decode; emits up to two results per item.
// ----------------------------------------------------------------------------
module lpsl_parse #(
   parameter int MAX_STRINGS = lpsl_pkg::MAX_STRINGS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  lpsl_pkg::req_type  item,
   output lpsl_pkg::push_type push
);

   localparam int SL_W = $clog2(MAX_STRINGS + 1);

   lpsl_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]           pos_ff, pos_in;
   logic [23:0]          acc_ff, acc_in;
   logic [SL_W-1:0]      left_ff, left_in;
   logic [31:0]          pay_ff, pay_in;
   logic [11:0]          idx_ff, idx_in;
   lpsl_pkg::status_type err_ff, err_in;

   logic [31:0] field;
   logic        field_done;
   logic        last_str;
   logic        finish;

   assign field      = {item.data_byte, acc_ff};
   assign field_done = (pos_ff == 2'd3);
   assign last_str   = (left_ff <= SL_W'(1));

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      left_in  = left_ff;
      pay_in   = pay_ff;
      idx_in   = idx_ff;
      err_in   = err_ff;
      finish   = 1'b0;
      push     = '0;

      if (item.has_byte) begin
         case (phase_ff)
            lpsl_pkg::PH_COUNT, lpsl_pkg::PH_LEN: begin
               if (field_done) begin
                  acc_in = '0;
                  pos_in = 2'd0;
                  if (phase_ff == lpsl_pkg::PH_COUNT) begin
                     if (field > 32'(MAX_STRINGS)) begin
                        err_in   = lpsl_pkg::ST_BIG;
                        phase_in = lpsl_pkg::PH_ERR;
                     end else begin
                        left_in  = field[SL_W-1:0];
                        phase_in = (field == 32'd0) ? lpsl_pkg::PH_TAIL : lpsl_pkg::PH_LEN;
                     end
                  end else begin
                     push.first_valid          = 1'b1;
                     push.first.kind           = lpsl_pkg::KIND_START;
                     push.first.string_index   = idx_ff;
                     push.first.string_length  = (field > 32'(lpsl_pkg::LEN_SAT)) ?
                                                 13'(lpsl_pkg::LEN_SAT) : field[12:0];
                     pay_in = field;
                     if (field == 32'd0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = lpsl_pkg::PH_PAY;
                     end
                  end
               end else begin
                  // field bytes arrive low first; accumulator was cleared
                  case (pos_ff)
                     2'd0:    acc_in[7:0]   = item.data_byte;
                     2'd1:    acc_in[15:8]  = item.data_byte;
                     default: acc_in[23:16] = item.data_byte;
                  endcase
                  pos_in = pos_ff + 2'd1;
               end
            end
            lpsl_pkg::PH_PAY: begin
               push.first_valid         = 1'b1;
               push.first.kind          = lpsl_pkg::KIND_BYTE;
               push.first.string_index  = idx_ff;
               push.first.payload_byte  = item.data_byte;
               pay_in = pay_ff - 32'd1;
               if (pay_ff == 32'd1) begin
                  finish = 1'b1;
               end
            end
            lpsl_pkg::PH_TAIL: begin
               err_in   = lpsl_pkg::ST_TRAIL;
               phase_in = lpsl_pkg::PH_ERR;
            end
            default: begin
            end
         endcase
      end

      if (finish) begin
         idx_in   = idx_ff + 12'd1;
         left_in  = (left_ff == '0) ? '0 : left_ff - SL_W'(1);
         phase_in = last_str ? lpsl_pkg::PH_TAIL : lpsl_pkg::PH_LEN;
      end

      push.first.last_result = ~item.end_of_request;

      if (item.end_of_request) begin
         push.second_valid       = 1'b1;
         push.second.kind        = lpsl_pkg::KIND_DONE;
         push.second.last_result = 1'b1;
         case (phase_in)
            lpsl_pkg::PH_COUNT: push.second.status = lpsl_pkg::ST_SHORT;
            lpsl_pkg::PH_LEN:   push.second.status = lpsl_pkg::ST_CUTLEN;
            lpsl_pkg::PH_PAY:   push.second.status = lpsl_pkg::ST_CUTPAY;
            lpsl_pkg::PH_TAIL:  push.second.status = lpsl_pkg::ST_OK;
            default:            push.second.status = err_in;
         endcase
         phase_in = lpsl_pkg::PH_COUNT;
         pos_in   = 2'd0;
         acc_in   = '0;
         left_in  = '0;
         pay_in   = '0;
         idx_in   = '0;
         err_in   = lpsl_pkg::ST_OK;
      end

      push.first_valid  = push.first_valid & fire;
      push.second_valid = push.second_valid & fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lpsl_pkg::PH_COUNT;
         pos_ff   <= 2'd0;
         acc_ff   <= '0;
         left_ff  <= '0;
         pay_ff   <= '0;
         idx_ff   <= '0;
         err_ff   <= lpsl_pkg::ST_OK;
      end else if (fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         pay_ff   <= pay_in;
         idx_ff   <= idx_in;
         err_ff   <= err_in;
      end
   end

endmodule

### src/lpsl_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsl_rsp_fifo
// Small result queue: takes up to two results a cycle, gives one unless rsp_stall is high.
// ----------------------------------------------------------------------------
module lpsl_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  lpsl_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lpsl_pkg::rsp_type  rsp_data
);

   localparam int DEPTH = lpsl_pkg::RSP_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lpsl_pkg::rsp_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   second_slot;
   logic [CNT_W-1:0]   n_push;
   logic               pop;

   assign room        = (count_ff <= CNT_W'(DEPTH - 2));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = entry_ff[head_ff];
   assign pop         = rsp_valid & ~rsp_stall;
   assign second_slot = tail_ff + PTR_W'(push.first_valid);
   assign n_push      = CNT_W'(push.first_valid) + CNT_W'(push.second_valid);

   always_comb begin
      head_in  = head_ff + PTR_W'(pop);
      tail_in  = tail_ff + PTR_W'(n_push);
      count_in = count_ff + n_push - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[second_slot] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

### src/length_prefixed_string_list_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_string_list_parser
// Deframes a request body: 4-byte LE count, then strings of 4-byte LE length
// plus payload; reports string starts, payload bytes and an end status.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one body byte per item (has_byte) and/or the end marker
//   (end_of_request). rsp_* carries string-start, payload-byte and done items;
//   last_result flags the final result caused by one request item.
//   An item is taken by an input register, decoded from it against the parser
//   state once the queue has room, and written into a 4-entry result queue;
//   results reach rsp_* only from the queue. Throughput is one item per
//   cycle while the queue has room. An item that carries a byte with a result
//   and the end marker gives two results, and the single-ported result queue
//   output then sets the pace at one result per cycle unless rsp_stall holds
//   it. req_stall rises when an item waits in the input register and the
//   queue has fewer than two free slots, so a stalled receiver backs up into
//   the input; nothing is dropped. Reset (synchronous) empties the queue and
//   puts the parser back at the count header of a new request.
// ----------------------------------------------------------------------------
module length_prefixed_string_list_parser #(
   parameter int MAX_STRINGS = lpsl_pkg::MAX_STRINGS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpsl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpsl_pkg::rsp_type rsp_data
);

   logic               in_valid_ff, in_valid_in;
   lpsl_pkg::req_type  in_item_ff;
   logic               room;
   logic               fire;
   logic               accept;
   lpsl_pkg::push_type push;

   assign fire        = in_valid_ff & room;
   assign req_stall   = in_valid_ff & ~room;
   assign accept      = req_valid & ~req_stall;
   assign in_valid_in = accept | (in_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
   end

   lpsl_parse #(
      .MAX_STRINGS(MAX_STRINGS)
   ) u_parse (
      .clock(clock),
      .reset(reset),
      .fire (fire),
      .item (in_item_ff),
      .push (push)
   );

   lpsl_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // end status always rides in the second slot and closes the item
   a_second_is_done: assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> (push.second.kind == lpsl_pkg::KIND_DONE) &&
                            push.second.last_result)
      else $error("end status result malformed");

   // byte-driven result is never a done item and is last only when alone
   a_first_shape: assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> (push.first.kind != lpsl_pkg::KIND_DONE) &&
                           (push.first.last_result == !push.second_valid))
      else $error("byte result malformed");

   // nothing is decoded unless an item sits in the input register
   a_push_needs_item: assert property (@(posedge clock) disable iff (reset)
      (push.first_valid || push.second_valid) |-> in_valid_ff && room)
      else $error("result pushed without a decoded item");

   // done items carry only a status
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == lpsl_pkg::KIND_DONE) |->
         (rsp_data.string_index == '0) && (rsp_data.string_length == '0) &&
         (rsp_data.payload_byte == '0))
      else $error("done item has stray fields");

endmodule
